/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pec_pkg.sv */
package pec_pkg;

    // Coordinate width and the widths that follow from it
    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;        // coordinate difference
    localparam int MA_W       = 2 * COORD_BITS + 1;    // wide multiplier operand (c12, c34)
    localparam int PROD_W     = MA_W + DIFF_W;         // multiplier product
    localparam int ACC_W      = PROD_W + 1;            // difference of two products
    localparam int DEN_W      = 2 * DIFF_W + 1;        // intersection denominator
    localparam int QB         = COORD_BITS + 1;        // quotient bits developed
    localparam int CNT_W      = $clog2(QB + 1);
    localparam int UOP_W      = 4;
    localparam int CFG_IDX_W  = 3;

    // Quotient saturation limits
    localparam logic [QB-1:0] Q_LIM     = QB'(1) << (COORD_BITS - 1);
    localparam logic [QB-1:0] Q_POS_MAX = Q_LIM - QB'(1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_AX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_AY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BY = 3'd3;

    // Multiply micro-ops: pairs (A then B) give acc = A - B
    localparam logic [UOP_W-1:0] UOP_SS_A   = 4'd0;   // side of S
    localparam logic [UOP_W-1:0] UOP_SS_B   = 4'd1;
    localparam logic [UOP_W-1:0] UOP_SE_A   = 4'd2;   // side of E
    localparam logic [UOP_W-1:0] UOP_SE_B   = 4'd3;
    localparam logic [UOP_W-1:0] UOP_C12_A  = 4'd4;
    localparam logic [UOP_W-1:0] UOP_C12_B  = 4'd5;
    localparam logic [UOP_W-1:0] UOP_C34_A  = 4'd6;
    localparam logic [UOP_W-1:0] UOP_C34_B  = 4'd7;
    localparam logic [UOP_W-1:0] UOP_DEN_A  = 4'd8;
    localparam logic [UOP_W-1:0] UOP_DEN_B  = 4'd9;
    localparam logic [UOP_W-1:0] UOP_XN_A   = 4'd10;
    localparam logic [UOP_W-1:0] UOP_XN_B   = 4'd11;
    localparam logic [UOP_W-1:0] UOP_YN_A   = 4'd12;
    localparam logic [UOP_W-1:0] UOP_YN_B   = 4'd13;
    localparam logic [UOP_W-1:0] UOP_LAST   = 4'd15;  // last accumulate cycle
    localparam logic [UOP_W-1:0] UOP_LAG    = 4'd2;   // operand + product stages

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DECIDE,
        ST_DX_START,
        ST_DX_WAIT,
        ST_DY_START,
        ST_DY_WAIT,
        ST_PUT_C,
        ST_PUT_E,
        ST_EDGE_END,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         final_vertex;
    } t_pec_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic                         out_valid;
        logic                         polygon_done;
    } t_pec_out;

endpackage

/* rtl/core/pec_div.sv */
module pec_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [pec_pkg::ACC_W-1:0]   i_num,
    input  logic signed [pec_pkg::DEN_W-1:0]   i_den,
    output logic                               o_done,
    output logic signed [pec_pkg::COORD_BITS-1:0] o_quot
);
    import pec_pkg::*;

    logic [ACC_W-1:0] w_num_mag;
    logic [DEN_W-1:0] w_den_mag;
    logic [ACC_W:0]   w_den_top;
    logic             w_ge;
    logic [QB-1:0]    w_qsat;
    logic [QB-1:0]    w_qneg;

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_rem;
    logic [ACC_W-1:0] r_dsh;
    logic [QB-1:0]    r_q;
    logic             r_neg;
    logic             r_big;
    logic             r_dz;

    // Operand magnitudes; divisor aligned to the top quotient bit
    assign w_num_mag = i_num[ACC_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
    assign w_den_mag = i_den[DEN_W-1] ? $unsigned(-i_den) : $unsigned(i_den);
    assign w_den_top = {w_den_mag, {QB{1'b0}}};
    assign w_ge      = (r_rem >= r_dsh);

    // Sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(QB);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_num_mag;
            r_dsh <= {w_den_mag, {(QB-1){1'b0}}};
            r_q   <= '0;
            r_neg <= i_num[ACC_W-1] ^ i_den[DEN_W-1];
            r_big <= ({1'b0, w_num_mag} >= w_den_top);
            r_dz  <= (w_den_mag == '0);
        end else if (r_run) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[QB-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    // Saturate to the coordinate range and apply the sign; a zero divisor gives 0
    assign w_qsat = (r_big || (r_q > Q_LIM)) ? Q_LIM : r_q;
    assign w_qneg = QB'(0) - w_qsat;

    always_comb begin
        if (r_dz) begin
            o_quot = '0;
        end else if (r_neg) begin
            o_quot = w_qneg[COORD_BITS-1:0];
        end else if (w_qsat > Q_POS_MAX) begin
            o_quot = Q_POS_MAX[COORD_BITS-1:0];
        end else begin
            o_quot = w_qsat[COORD_BITS-1:0];
        end
    end

    assign o_done = r_done;

endmodule

/* rtl/core/polygon_edge_clip.sv */
// Each edge runs the multiply micro-op sequence; a crossing adds two divisions.
// A vertex holds the block for its edge (the final vertex also for the closing edge) plus
// output stalls; the next vertex is taken once the block is back in idle.
// Built on the shared 33x17 multiplier and the bit-serial divider; one vertex at a time.
// A first vertex opens no edge unless final; results leave through a one-deep output register.
// Reset (synchronous, active low) clears the line to (0,0)-(1,0) and drops any open polygon.
`include "assert_macros.svh"

module polygon_edge_clip (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  pec_pkg::t_pec_in                  i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output pec_pkg::t_pec_out                 o_out_data,
    input  logic                              i_cfg_we,
    input  logic [pec_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pec_pkg::COORD_BITS-1:0]    i_cfg_data
);
    import pec_pkg::*;

    // Configuration
    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;

    // Polygon state and current edge
    t_state                       r_state, n_state;
    logic                         r_have;
    logic signed [COORD_BITS-1:0] r_start_x, r_start_y, r_last_x, r_last_y;
    logic signed [COORD_BITS-1:0] r_vx, r_vy;
    logic                         r_fin;
    logic                         r_wrap;
    logic signed [COORD_BITS-1:0] r_sx, r_sy, r_ex, r_ey;
    logic signed [DIFF_W-1:0]     r_dlx, r_dly;

    // Shared multiplier pipeline
    logic [UOP_W-1:0]             r_uop;
    logic [UOP_W-1:0]             w_acc_k;
    logic signed [MA_W-1:0]       w_opa, r_opa;
    logic signed [DIFF_W-1:0]     w_bu, w_bv, w_opb, r_opb;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]      r_acc, w_diff;
    logic                         r_s_in, r_e_in;
    logic signed [MA_W-1:0]       r_c12, r_c34;
    logic signed [DEN_W-1:0]      r_den;
    logic signed [ACC_W-1:0]      r_xn, r_yn;
    logic signed [COORD_BITS-1:0] r_cx, r_cy;

    // Result staging: one pending result, then the output register
    logic                         r_pend_v;
    logic signed [COORD_BITS-1:0] r_pend_x, r_pend_y;
    logic                         r_ov;
    t_pec_out                     r_out;

    // Control
    logic                         w_accept;
    logic                         w_slot;
    logic                         w_put_ok, w_flush_ok;
    logic                         w_put, w_flush, w_push, w_wrap_go;
    logic signed [COORD_BITS-1:0] w_put_x, w_put_y;
    logic                         w_div_start, w_div_done;
    logic signed [ACC_W-1:0]      w_div_num;
    logic signed [COORD_BITS-1:0] w_quot;

    assign o_in_stall  = (r_state != ST_IDLE) || !i_rst_n;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot      = !r_ov || !i_out_stall;
    assign w_put_ok    = !r_pend_v || w_slot;
    assign w_flush_ok  = (!r_fin && !r_pend_v) || w_slot;
    assign w_push      = (w_put && r_pend_v) || (w_flush && (r_pend_v || r_fin));
    assign w_wrap_go   = (r_state == ST_EDGE_END) && r_fin && !r_wrap;
    assign w_acc_k     = r_uop - UOP_LAG;
    assign w_diff      = r_acc - ACC_W'(r_prod);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Shared divider for the two intersection quotients
    pec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (r_have || i_in_data.final_vertex)) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_uop == UOP_LAST) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_s_in != r_e_in) begin
                    n_state = ST_DX_START;
                end else if (r_s_in) begin
                    n_state = ST_PUT_E;
                end else begin
                    n_state = ST_EDGE_END;
                end
            end
            ST_DX_START: n_state = ST_DX_WAIT;
            ST_DX_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_DY_START;
                end
            end
            ST_DY_START: n_state = ST_DY_WAIT;
            ST_DY_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_PUT_C;
                end
            end
            ST_PUT_C: begin
                if (w_put_ok) begin
                    n_state = r_e_in ? ST_PUT_E : ST_EDGE_END;
                end
            end
            ST_PUT_E: begin
                if (w_put_ok) begin
                    n_state = ST_EDGE_END;
                end
            end
            ST_EDGE_END: n_state = w_wrap_go ? ST_MUL : ST_FLUSH;
            ST_FLUSH: begin
                if (w_flush_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_put       = 1'b0;
        w_flush     = 1'b0;
        w_put_x     = r_ex;
        w_put_y     = r_ey;
        w_div_start = 1'b0;
        w_div_num   = r_xn;
        case (r_state)
            ST_DX_START: w_div_start = 1'b1;
            ST_DY_START: begin
                w_div_start = 1'b1;
                w_div_num   = r_yn;
            end
            ST_PUT_C: begin
                w_put   = w_put_ok;
                w_put_x = r_cx;
                w_put_y = r_cy;
            end
            ST_PUT_E: w_put = w_put_ok;
            ST_FLUSH: w_flush = w_flush_ok;
            default: ;
        endcase
    end

    // Multiplier operand select: A is wide, B is a difference of two narrow terms
    always_comb begin
        w_opa = '0;
        w_bu  = '0;
        w_bv  = '0;
        case (r_uop)
            UOP_SS_A: begin
                w_opa = MA_W'(r_dly);
                w_bu  = DIFF_W'(r_sx);
                w_bv  = DIFF_W'(r_ax);
            end
            UOP_SS_B: begin
                w_opa = MA_W'(r_dlx);
                w_bu  = DIFF_W'(r_sy);
                w_bv  = DIFF_W'(r_ay);
            end
            UOP_SE_A: begin
                w_opa = MA_W'(r_dly);
                w_bu  = DIFF_W'(r_ex);
                w_bv  = DIFF_W'(r_ax);
            end
            UOP_SE_B: begin
                w_opa = MA_W'(r_dlx);
                w_bu  = DIFF_W'(r_ey);
                w_bv  = DIFF_W'(r_ay);
            end
            UOP_C12_A: begin
                w_opa = MA_W'(r_ax);
                w_bu  = DIFF_W'(r_by);
            end
            UOP_C12_B: begin
                w_opa = MA_W'(r_ay);
                w_bu  = DIFF_W'(r_bx);
            end
            UOP_C34_A: begin
                w_opa = MA_W'(r_sx);
                w_bu  = DIFF_W'(r_ey);
            end
            UOP_C34_B: begin
                w_opa = MA_W'(r_sy);
                w_bu  = DIFF_W'(r_ex);
            end
            UOP_DEN_A: begin
                w_opa = MA_W'(r_dlx);
                w_bu  = DIFF_W'(r_sy);
                w_bv  = DIFF_W'(r_ey);
            end
            UOP_DEN_B: begin
                w_opa = MA_W'(r_dly);
                w_bu  = DIFF_W'(r_sx);
                w_bv  = DIFF_W'(r_ex);
            end
            UOP_XN_A: begin
                w_opa = r_c12;
                w_bu  = DIFF_W'(r_sx);
                w_bv  = DIFF_W'(r_ex);
            end
            UOP_XN_B: begin
                w_opa = r_c34;
                w_bu  = r_dlx;
            end
            UOP_YN_A: begin
                w_opa = r_c12;
                w_bu  = DIFF_W'(r_sy);
                w_bv  = DIFF_W'(r_ey);
            end
            UOP_YN_B: begin
                w_opa = r_c34;
                w_bu  = r_dly;
            end
            default: ;
        endcase
    end

    assign w_opb = w_bu - w_bv;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_have   <= 1'b0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
            r_uop    <= '0;
            r_ax     <= '0;
            r_ay     <= '0;
            r_bx     <= COORD_BITS'(1);
            r_by     <= '0;
        end else begin
            r_state <= n_state;

            if (w_accept) begin
                r_have <= 1'b1;
            end else if (w_flush && r_fin) begin
                r_have <= 1'b0;
            end

            if (w_put) begin
                r_pend_v <= 1'b1;
            end else if (w_flush) begin
                r_pend_v <= 1'b0;
            end

            if (w_push) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end

            if (w_accept || w_wrap_go) begin
                r_uop <= '0;
            end else if (r_state == ST_MUL) begin
                r_uop <= r_uop + UOP_W'(1);
            end

            // Line registers
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LINE_AX: r_ax <= i_cfg_data;
                    CFG_LINE_AY: r_ay <= i_cfg_data;
                    CFG_LINE_BX: r_bx <= i_cfg_data;
                    CFG_LINE_BY: r_by <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Vertex capture and edge setup
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vx     <= i_in_data.vertex_x;
            r_vy     <= i_in_data.vertex_y;
            r_fin    <= i_in_data.final_vertex;
            r_last_x <= i_in_data.vertex_x;
            r_last_y <= i_in_data.vertex_y;
            r_ex     <= i_in_data.vertex_x;
            r_ey     <= i_in_data.vertex_y;
            r_dlx    <= DIFF_W'(r_ax) - DIFF_W'(r_bx);
            r_dly    <= DIFF_W'(r_ay) - DIFF_W'(r_by);
            r_wrap   <= !r_have;
            if (r_have) begin
                r_sx <= r_last_x;
                r_sy <= r_last_y;
            end else begin
                // first vertex: its own edge, run only if it is final, is the wrap edge onto itself
                r_start_x <= i_in_data.vertex_x;
                r_start_y <= i_in_data.vertex_y;
                r_sx      <= i_in_data.vertex_x;
                r_sy      <= i_in_data.vertex_y;
            end
        end else if (w_wrap_go) begin
            // closing edge from the final vertex back to the first
            r_sx   <= r_vx;
            r_sy   <= r_vy;
            r_ex   <= r_start_x;
            r_ey   <= r_start_y;
            r_wrap <= 1'b1;
        end
    end

    // Multiply pipeline: operands, product, accumulate two stages behind
    always_ff @(posedge i_clk) begin
        r_opa  <= w_opa;
        r_opb  <= w_opb;
        r_prod <= r_opa * r_opb;
        if (r_state == ST_MUL) begin
            case (w_acc_k)
                UOP_SS_A, UOP_SE_A, UOP_C12_A, UOP_C34_A,
                UOP_DEN_A, UOP_XN_A, UOP_YN_A: r_acc <= ACC_W'(r_prod);
                UOP_SS_B:  r_s_in <= w_diff[ACC_W-1];
                UOP_SE_B:  r_e_in <= w_diff[ACC_W-1];
                UOP_C12_B: r_c12  <= w_diff[MA_W-1:0];
                UOP_C34_B: r_c34  <= w_diff[MA_W-1:0];
                UOP_DEN_B: r_den  <= w_diff[DEN_W-1:0];
                UOP_XN_B:  r_xn   <= w_diff;
                UOP_YN_B:  r_yn   <= w_diff;
                default: ;
            endcase
        end
    end

    // Intersection quotients
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DX_WAIT && w_div_done) begin
            r_cx <= w_quot;
        end
        if (r_state == ST_DY_WAIT && w_div_done) begin
            r_cy <= w_quot;
        end
    end

    // Pending result and output register payload
    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_pend_x <= w_put_x;
            r_pend_y <= w_put_y;
        end
        if (w_push) begin
            r_out.out_x        <= r_pend_v ? r_pend_x : '0;
            r_out.out_y        <= r_pend_v ? r_pend_y : '0;
            r_out.out_valid    <= r_pend_v;
            r_out.polygon_done <= w_flush && r_fin;
        end
    end

    // Checks
    `AST_IMPL(a_cross_only_on_change, (r_state == ST_DX_START), (r_s_in != r_e_in), "crossing without side change")
    `AST_NEXT(a_edge_starts, (w_accept && (r_have || i_in_data.final_vertex)), (r_state == ST_MUL), "edge did not start")
    `AST_NEXT(a_done_marked, (w_flush && r_fin), (r_ov && r_out.polygon_done), "final result not marked done")
    `AST_IMPL(a_idle_no_pending, (r_state == ST_IDLE), (!r_pend_v), "pending result left in idle")

endmodule

/* bench/polygon_edge_clip_tb.sv */
module polygon_edge_clip_tb;
    import pec_pkg::*;

    localparam int CB            = COORD_BITS;
    localparam int SETTLE_CYCLES = 200;    // longer than the slowest vertex
    localparam int LONG_HOLD     = 400;

    // Unused register indexes; writes there must not disturb the line
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef logic signed [CB-1:0] t_coord;
    typedef logic signed [127:0]  t_wide;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_pec_in              i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_pec_out             o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CB-1:0]        i_cfg_data = '0;

    polygon_edge_clip dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clip line as the block should hold it
    t_coord clip_ax = 0;
    t_coord clip_ay = 0;
    t_coord clip_bx = 1;
    t_coord clip_by = 0;

    // Open polygon tracking
    t_coord poly_first_x = 0;
    t_coord poly_first_y = 0;
    t_coord prev_x = 0;
    t_coord prev_y = 0;
    bit     poly_open = 1'b0;

    // Clipped vertices of the current transaction, then the ones still owed
    t_pec_out clipped_step [0:3];
    int       clipped_n;
    t_pec_out expected_vertices [$];

    t_pec_in pending_vertices [$];
    int      vertices_queued = 0;
    int      vertices_accepted = 0;
    int      vertices_checked = 0;
    int      error_count = 0;

    bit sender_idle_en = 1'b1;
    bit receiver_stall_en = 1'b1;
    int send_gap = 0;
    int stall_left = 0;
    int long_hold_left = 0;
    bit offer;
    bit hold_out;

    // ------------------------------------------------------------------
    // Clipping predictor
    // ------------------------------------------------------------------

    // Negative means inside
    function automatic t_wide side_of(t_coord x, t_coord y);
        t_wide ax = clip_ax;
        t_wide ay = clip_ay;
        t_wide bx = clip_bx;
        t_wide by = clip_by;
        t_wide wx = x;
        t_wide wy = y;
        return (bx - ax) * (wy - ay) - (by - ay) * (wx - ax);
    endfunction

    // Truncating divide, clamped to the coordinate range; zero divisor gives 0
    function automatic t_coord quotient_sat(t_wide num, t_wide den);
        t_wide q;
        t_wide lim;
        if (den == 0)
            return '0;
        q = num / den;
        lim = 1;
        lim = lim << (CB - 1);
        if (q > lim - 1)
            q = lim - 1;
        else if (q < -lim)
            q = -lim;
        return q[CB-1:0];
    endfunction

    task automatic emit_vertex(t_coord x, t_coord y, logic is_vertex);
        clipped_step[clipped_n] = '{out_x: x, out_y: y, out_valid: is_vertex,
                                    polygon_done: 1'b0};
        clipped_n++;
    endtask

    task automatic emit_crossing(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        t_wide ax = clip_ax;
        t_wide ay = clip_ay;
        t_wide bx = clip_bx;
        t_wide by = clip_by;
        t_wide wsx = sx;
        t_wide wsy = sy;
        t_wide wex = ex;
        t_wide wey = ey;
        t_wide c12, c34, den, xn, yn;
        c12 = ax * by - ay * bx;
        c34 = wsx * wey - wsy * wex;
        den = (ax - bx) * (wsy - wey) - (ay - by) * (wsx - wex);
        xn  = c12 * (wsx - wex) - (ax - bx) * c34;
        yn  = c12 * (wsy - wey) - (ay - by) * c34;
        emit_vertex(quotient_sat(xn, den), quotient_sat(yn, den), 1'b1);
    endtask

    // One edge S -> E, by the four inside/outside cases
    task automatic clip_edge(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        bit s_in;
        bit e_in;
        s_in = side_of(sx, sy) < 0;
        e_in = side_of(ex, ey) < 0;
        if (s_in && e_in) begin
            emit_vertex(ex, ey, 1'b1);
        end else if (!s_in && e_in) begin
            emit_crossing(sx, sy, ex, ey);
            emit_vertex(ex, ey, 1'b1);
        end else if (s_in && !e_in) begin
            emit_crossing(sx, sy, ex, ey);
        end
    endtask

    task automatic predict_clip(t_pec_in v);
        clipped_n = 0;
        if (poly_open) begin
            clip_edge(prev_x, prev_y, v.vertex_x, v.vertex_y);
        end else begin
            poly_first_x = v.vertex_x;
            poly_first_y = v.vertex_y;
            poly_open = 1'b1;
        end
        prev_x = v.vertex_x;
        prev_y = v.vertex_y;
        if (v.final_vertex) begin
            // closing edge back to the first vertex; empty result gets an end marker
            clip_edge(v.vertex_x, v.vertex_y, poly_first_x, poly_first_y);
            if (clipped_n == 0)
                emit_vertex('0, '0, 1'b0);
            clipped_step[clipped_n-1].polygon_done = 1'b1;
            poly_open = 1'b0;
        end
        for (int i = 0; i < clipped_n; i++)
            expected_vertices.insert(expected_vertices.size(), clipped_step[i]);
    endtask

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offer = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predict_clip(i_in_data);
                vertices_accepted++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_vertices.size() > 0) begin
                    i_in_data <= pending_vertices.pop_front();
                    offer = 1'b1;
                    if (sender_idle_en)
                        send_gap = draw_gap();
                end
            end
            i_in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Output monitor and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_vertices.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction x=%0d y=%0d",
                                              o_out_data.out_x, o_out_data.out_y));
                end else begin
                    t_pec_out want;
                    want = expected_vertices.pop_front();
                    if (o_out_data.out_x !== want.out_x)
                        report_mismatch($sformatf("#%0d out_x %0d, want %0d", vertices_checked,
                                                  o_out_data.out_x, want.out_x));
                    if (o_out_data.out_y !== want.out_y)
                        report_mismatch($sformatf("#%0d out_y %0d, want %0d", vertices_checked,
                                                  o_out_data.out_y, want.out_y));
                    if (o_out_data.out_valid !== want.out_valid)
                        report_mismatch($sformatf("#%0d out_valid %b, want %b",
                                                  vertices_checked, o_out_data.out_valid,
                                                  want.out_valid));
                    if (o_out_data.polygon_done !== want.polygon_done)
                        report_mismatch($sformatf("#%0d polygon_done %b, want %b",
                                                  vertices_checked, o_out_data.polygon_done,
                                                  want.polygon_done));
                end
                vertices_checked++;
                // long back-pressure so the block fills up and stalls its input
                if (vertices_checked == 25 || vertices_checked == 200)
                    long_hold_left = LONG_HOLD;
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                hold_out = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                hold_out = 1'b1;
            end else begin
                hold_out = 1'b0;
                if (receiver_stall_en)
                    stall_left = draw_gap();
            end
            i_out_stall <= hold_out;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic add_vertex(int x, int y, bit fin);
        t_pec_in v;
        v.vertex_x = t_coord'(x);
        v.vertex_y = t_coord'(y);
        v.final_vertex = fin;
        pending_vertices.insert(pending_vertices.size(), v);
        vertices_queued++;
    endtask

    // spread 0 means full coordinate range
    task automatic add_random_polygon(int spread, output int n_added);
        int nv;
        nv = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(3, 7);
        for (int i = 0; i < nv; i++) begin
            if (spread == 0)
                add_vertex(int'($urandom), int'($urandom), i == nv - 1);
            else
                add_vertex(int'($urandom_range(0, 2 * spread)) - spread,
                           int'($urandom_range(0, 2 * spread)) - spread, i == nv - 1);
        end
        n_added = nv;
    endtask

    task automatic add_polygons(int n_items, int spread, int wide_pct);
        int done_items;
        int n;
        done_items = 0;
        while (done_items < n_items) begin
            if (int'($urandom_range(0, 99)) < wide_pct)
                add_random_polygon(0, n);
            else
                add_random_polygon(spread, n);
            done_items += n;
        end
    endtask

    // Block idle: all items taken, all results back, last item finished
    task automatic wait_idle();
        while (vertices_accepted != vertices_queued || expected_vertices.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CB-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_LINE_AX: clip_ax = value;
            CFG_LINE_AY: clip_ay = value;
            CFG_LINE_BX: clip_bx = value;
            CFG_LINE_BY: clip_by = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_line(int ax, int ay, int bx, int by);
        write_reg(CFG_LINE_AX, t_coord'(ax));
        write_reg(CFG_LINE_AY, t_coord'(ay));
        write_reg(CFG_LINE_BX, t_coord'(bx));
        write_reg(CFG_LINE_BY, t_coord'(by));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset line (0,0)-(1,0): inside is y < 0
        add_vertex(5, -3, 1'b1);                   // lone vertex, inside
        add_vertex(7, 4, 1'b1);                    // lone vertex, outside
        add_vertex(-10, -10, 1'b0);                // triangle across the line
        add_vertex(10, -10, 1'b0);
        add_vertex(0, 10, 1'b1);
        add_vertex(0, 5, 1'b0);                    // closing step emits only the end marker
        add_vertex(2, -5, 1'b0);
        add_vertex(4, 5, 1'b0);
        add_vertex(6, 5, 1'b1);
        add_vertex(-32768, -32768, 1'b0);          // full-range square
        add_vertex(32767, -32768, 1'b0);
        add_vertex(32767, 32767, 1'b0);
        add_vertex(-32768, 32767, 1'b1);
        add_vertex(1, 0, 1'b0);                    // on the line counts as outside
        add_vertex(2, 2, 1'b0);
        add_vertex(3, 0, 1'b1);
        add_vertex(-1, -1, 1'b0);                  // fully inside
        add_vertex(-32768, -1, 1'b1);
        wait_idle();

        // Extreme diagonal lines, full-range polygons
        set_line(-32768, -32768, 32767, 32767);
        add_polygons(40, 0, 100);
        wait_idle();

        set_line(32767, -32768, -32768, 32767);
        write_reg(CFG_SPARE_LO, t_coord'($urandom));
        write_reg(CFG_SPARE_HI, t_coord'($urandom));
        add_polygons(40, 0, 100);
        wait_idle();

        // Degenerate line: nothing is ever inside
        set_line(100, 100, 100, 100);
        add_polygons(20, 300, 20);
        wait_idle();

        // Random lines near the vertex cloud
        for (int phase = 0; phase < 5; phase++) begin
            sender_idle_en    = (phase != 2);
            receiver_stall_en = (phase != 2);
            set_line(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
                     int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300);
            add_polygons(40, 300, 20);
            wait_idle();
        end

        if (error_count == 0)
            $display("polygon_edge_clip_tb: done, clean");
        else
            $display("polygon_edge_clip_tb: done, errors");
        $finish;
    end

    // Run limit
    initial begin
        #5000000;
        $display("polygon_edge_clip_tb: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/pec_pkg.sv
rtl/core/pec_div.sv
rtl/core/polygon_edge_clip.sv
bench/polygon_edge_clip_tb.sv
